// File: rtl/core/mfap_pkg.sv
package mfap_pkg;

    // Default sizing
    localparam int MaxNodesDef      = 128;
    localparam int ResidualWidthDef = 32;

    // Fixed field widths
    localparam int NodeW = 7;
    localparam int CapW  = 16;
    localparam int FlowW = 32;
    localparam int IdxW  = 2;

    localparam logic [FlowW-1:0] FlowMax = '1;

    // Request actions
    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ADD   = 2'd1,
        ACT_SOLVE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Register indexes
    typedef enum logic [IdxW-1:0] {
        REG_NODE_COUNT = 2'd0,
        REG_SOURCE     = 2'd1,
        REG_SINK       = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    // Controller states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR1,
        S_ADD_WR2,
        S_SOLVE_INIT,
        S_VIS_CLR,
        S_POP,
        S_POP_WAIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_BN_PAR,
        S_BN_RES,
        S_BN_MIN,
        S_UP_INIT,
        S_UP_PAR,
        S_UP_RD,
        S_UP_WR1,
        S_UP_WR2,
        S_FLOW,
        S_EMIT
    } state_t;

    // Configuration seen by the core
    typedef struct packed {
        logic [NodeW-1:0] node_count;
        logic [NodeW-1:0] source_node;
        logic [NodeW-1:0] sink_node;
    } cfg_t;

    // Result handoff from core to output stage
    typedef struct packed {
        logic             busy;
        logic             emit;
        logic [FlowW-1:0] value;
    } core_stat_t;

endpackage

// File: rtl/core/mfap_ram.sv
module mfap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/mfap_core.sv
module mfap_core
    import mfap_pkg::*;
#(
    parameter int MAX_NODES      = MaxNodesDef,
    parameter int RESIDUAL_WIDTH = ResidualWidthDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              req_take,
    input  logic [1:0]        req_action,
    input  logic [NodeW-1:0]  req_end_a,
    input  logic [NodeW-1:0]  req_end_b,
    input  logic [CapW-1:0]   req_capacity,
    input  logic              out_room,
    output core_stat_t        stat
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int RD    = MAX_NODES * MAX_NODES;
    localparam int RAW   = $clog2(RD);
    localparam int RW    = RESIDUAL_WIDTH;
    localparam logic [RW-1:0]  ResMax  = '1;
    localparam logic [RAW-1:0] ClrLast = RAW'(RD - 1);
    localparam logic [NW:0]    Full    = (NW+1)'(MAX_NODES);

    // Control and datapath registers
    state_t            state_reg, state_next;
    logic [NW:0]       sp_reg, sp_next;
    logic [NW-1:0]     u_reg, u_next;
    logic [NW-1:0]     v_reg, v_next;
    logic [NW:0]       guard_reg, guard_next;
    logic [RW-1:0]     bn_reg, bn_next;
    logic [FlowW-1:0]  flow_reg, flow_next;
    logic [RAW-1:0]    clr_reg, clr_next;
    logic [NW-1:0]     ea_reg, ea_next;
    logic [NW-1:0]     eb_reg, eb_next;
    logic [CapW-1:0]   cap_reg, cap_next;
    logic [NW-1:0]     n_reg, n_next;
    logic [NW-1:0]     s_reg, s_next;
    logic [NW-1:0]     t_reg, t_next;

    // Memory ports
    logic              res_we, res_re;
    logic [RAW-1:0]    res_waddr, res_raddr;
    logic [RW-1:0]     res_wdata, res_rdata;
    // Parent entries carry the visited mark in their top bit
    logic              par_we, par_re;
    logic [NW-1:0]     par_waddr, par_raddr;
    logic [NW:0]       par_wdata, par_rdata;
    logic              stk_we, stk_re;
    logic [NW-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

    // Request decode
    int unsigned       n_full, s_full, t_full, a_full, b_full;
    logic              add_ok, solve_ok;
    logic [RW:0]       add_sum, back_sum;
    logic [RW-1:0]     add_sat, back_sat;
    logic [63:0]       flow_room;

    function automatic logic [RAW-1:0] res_addr(input logic [NW-1:0] row,
                                                input logic [NW-1:0] col);
        res_addr = RAW'(RAW'(row) * RAW'(MAX_NODES) + RAW'(col));
    endfunction

    always_comb
    begin
        n_full   = (32'(cfg.node_count) < MAX_NODES) ? 32'(cfg.node_count)
                                                     : 32'(MAX_NODES - 1);
        s_full   = 32'(cfg.source_node);
        t_full   = 32'(cfg.sink_node);
        a_full   = 32'(req_end_a);
        b_full   = 32'(req_end_b);
        add_ok   = (a_full != 0) && (b_full != 0) && (a_full < MAX_NODES)
                   && (b_full < MAX_NODES) && (a_full != b_full);
        solve_ok = (s_full >= 1) && (s_full <= n_full) && (t_full >= 1)
                   && (t_full <= n_full) && (s_full != t_full);
    end

    // Saturating adds on residual entries
    always_comb
    begin
        add_sum   = {1'b0, res_rdata} + (RW+1)'(cap_reg);
        add_sat   = add_sum[RW] ? ResMax : add_sum[RW-1:0];
        back_sum  = {1'b0, res_rdata} + {1'b0, bn_reg};
        back_sat  = back_sum[RW] ? ResMax : back_sum[RW-1:0];
        flow_room = 64'(FlowMax - flow_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:      if (clr_reg == ClrLast) state_next = S_IDLE;
            S_IDLE:
            begin
                if (req_take)
                begin
                    case (action_t'(req_action))
                        ACT_CLEAR: state_next = S_CLEAR;
                        ACT_ADD:   state_next = add_ok ? S_ADD_RD : S_IDLE;
                        ACT_SOLVE: state_next = solve_ok ? S_SOLVE_INIT : S_EMIT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:     state_next = S_ADD_WR1;
            S_ADD_WR1:    state_next = S_ADD_WR2;
            S_ADD_WR2:    state_next = S_IDLE;
            S_SOLVE_INIT: state_next = S_VIS_CLR;
            S_VIS_CLR:    state_next = (v_reg == NW'(1)) ? S_POP : S_VIS_CLR;
            S_POP:        state_next = (sp_reg == '0) ? S_EMIT : S_POP_WAIT;
            S_POP_WAIT:   state_next = (stk_rdata == t_reg) ? S_BN_PAR : S_SCAN_RD;
            S_SCAN_RD:    state_next = (v_reg == '0) ? S_POP : S_SCAN_EV;
            S_SCAN_EV:    state_next = S_SCAN_RD;
            S_BN_PAR:     state_next = (v_reg == s_reg || guard_reg == Full)
                                       ? S_UP_INIT : S_BN_RES;
            S_BN_RES:     state_next = S_BN_MIN;
            S_BN_MIN:     state_next = S_BN_PAR;
            S_UP_INIT:    state_next = S_UP_PAR;
            S_UP_PAR:     state_next = (v_reg == s_reg || guard_reg == Full)
                                       ? S_FLOW : S_UP_RD;
            S_UP_RD:      state_next = S_UP_WR1;
            S_UP_WR1:     state_next = S_UP_WR2;
            S_UP_WR2:     state_next = S_UP_PAR;
            S_FLOW:       state_next = S_SOLVE_INIT;
            S_EMIT:       if (out_room) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        res_we    = 1'b0;
        res_waddr = '0;
        res_wdata = '0;
        res_re    = 1'b0;
        res_raddr = '0;
        par_we    = 1'b0;
        par_waddr = '0;
        par_wdata = '0;
        par_re    = 1'b0;
        par_raddr = v_reg;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;
        case (state_reg)
            S_CLEAR:
            begin
                res_we    = 1'b1;
                res_waddr = clr_reg;
            end
            S_ADD_RD:
            begin
                res_re    = 1'b1;
                res_raddr = res_addr(ea_reg, eb_reg);
            end
            S_ADD_WR1:
            begin
                res_we    = 1'b1;
                res_waddr = res_addr(ea_reg, eb_reg);
                res_wdata = add_sat;
                res_re    = 1'b1;
                res_raddr = res_addr(eb_reg, ea_reg);
            end
            S_ADD_WR2:
            begin
                res_we    = 1'b1;
                res_waddr = res_addr(eb_reg, ea_reg);
                res_wdata = add_sat;
            end
            S_SOLVE_INIT:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = s_reg;
            end
            S_VIS_CLR:
            begin
                // Only the source starts out visited
                par_we    = 1'b1;
                par_waddr = v_reg;
                par_wdata = {(v_reg == s_reg), {NW{1'b0}}};
            end
            S_POP:
            begin
                stk_re    = (sp_reg != '0);
                stk_raddr = NW'(sp_reg - 1'b1);
            end
            S_SCAN_RD:
            begin
                res_re    = (v_reg != '0);
                res_raddr = res_addr(u_reg, v_reg);
                par_re    = (v_reg != '0);
            end
            S_SCAN_EV:
            begin
                if (!par_rdata[NW] && res_rdata != '0 && sp_reg != Full)
                begin
                    par_we    = 1'b1;
                    par_waddr = v_reg;
                    par_wdata = {1'b1, u_reg};
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[NW-1:0];
                    stk_wdata = v_reg;
                end
            end
            S_BN_PAR, S_UP_PAR:
            begin
                par_re = 1'b1;
            end
            S_BN_RES, S_UP_RD:
            begin
                res_re    = 1'b1;
                res_raddr = res_addr(par_rdata[NW-1:0], v_reg);
            end
            S_UP_WR1:
            begin
                res_we    = 1'b1;
                res_waddr = res_addr(u_reg, v_reg);
                res_wdata = res_rdata - bn_reg;
                res_re    = 1'b1;
                res_raddr = res_addr(v_reg, u_reg);
            end
            S_UP_WR2:
            begin
                res_we    = 1'b1;
                res_waddr = res_addr(v_reg, u_reg);
                res_wdata = back_sat;
            end
            default:
            begin
                res_we = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        sp_next      = sp_reg;
        u_next       = u_reg;
        v_next       = v_reg;
        guard_next   = guard_reg;
        bn_next      = bn_reg;
        flow_next    = flow_reg;
        clr_next     = clr_reg;
        ea_next      = ea_reg;
        eb_next      = eb_reg;
        cap_next     = cap_reg;
        n_next       = n_reg;
        s_next       = s_reg;
        t_next       = t_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                ea_next  = NW'(req_end_a);
                eb_next  = NW'(req_end_b);
                cap_next = req_capacity;
                n_next   = NW'(n_full);
                s_next   = NW'(s_full);
                t_next   = NW'(t_full);
                if (req_take && action_t'(req_action) == ACT_CLEAR)
                begin
                    clr_next  = '0;
                    flow_next = '0;
                end
            end
            S_SOLVE_INIT:
            begin
                sp_next = (NW+1)'(1);
                v_next  = n_reg;
            end
            S_VIS_CLR:
            begin
                v_next = v_reg - 1'b1;
            end
            S_POP:
            begin
                if (sp_reg != '0)
                begin
                    sp_next = sp_reg - 1'b1;
                end
            end
            S_POP_WAIT:
            begin
                u_next     = stk_rdata;
                v_next     = (stk_rdata == t_reg) ? t_reg : n_reg;
                guard_next = '0;
                bn_next    = ResMax;
            end
            S_SCAN_EV:
            begin
                if (!par_rdata[NW] && res_rdata != '0 && sp_reg != Full)
                begin
                    sp_next = sp_reg + 1'b1;
                end
                v_next = v_reg - 1'b1;
            end
            S_BN_RES:
            begin
                u_next = par_rdata[NW-1:0];
            end
            S_BN_MIN:
            begin
                if (res_rdata < bn_reg)
                begin
                    bn_next = res_rdata;
                end
                v_next     = u_reg;
                guard_next = guard_reg + 1'b1;
            end
            S_UP_INIT:
            begin
                v_next     = t_reg;
                guard_next = '0;
            end
            S_UP_RD:
            begin
                u_next = par_rdata[NW-1:0];
            end
            S_UP_WR2:
            begin
                v_next     = u_reg;
                guard_next = guard_reg + 1'b1;
            end
            S_FLOW:
            begin
                if (64'(bn_reg) >= flow_room)
                begin
                    flow_next = FlowMax;
                end
                else
                begin
                    flow_next = flow_reg + FlowW'(bn_reg);
                end
            end
            default:
            begin
                sp_next = sp_reg;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            flow_reg    <= '0;
            sp_reg      <= '0;
            guard_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            flow_reg    <= flow_next;
            sp_reg      <= sp_next;
            guard_reg   <= guard_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        bn_reg  <= bn_next;
        ea_reg  <= ea_next;
        eb_reg  <= eb_next;
        cap_reg <= cap_next;
        n_reg   <= n_next;
        s_reg   <= s_next;
        t_reg   <= t_next;
    end

    // Residual capacity matrix
    mfap_ram #(.WIDTH(RW), .DEPTH(RD)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (res_re),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // Search tree parents with visited marks
    mfap_ram #(.WIDTH(NW+1), .DEPTH(MAX_NODES)) u_par_ram (
        .clk   (clk),
        .we    (par_we),
        .waddr (par_waddr),
        .wdata (par_wdata),
        .re    (par_re),
        .raddr (par_raddr),
        .rdata (par_rdata)
    );

    // DFS stack
    mfap_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.emit  = (state_reg == S_EMIT) && out_room;
    assign stat.value = flow_reg;

endmodule

// File: rtl/core/max_flow_augmenting_path.sv
// Maximum flow (Ford-Fulkerson, depth-first augmenting paths) over a residual
// capacity matrix of MAX_NODES x MAX_NODES entries held in one synchronous RAM.
// After reset, and after every clear request, the block sweeps the whole
// matrix one entry per cycle with stall high; configuration writes are still
// taken. An add request does a read-modify-write of both directions. A solve
// request runs until no path is left: each search first clears the visited
// marks kept with the parent entries, then scans the residual row of each
// node popped from the stack, and each augmentation walks the path edge by
// edge, all bound by the single residual RAM port. A solve returns one
// result, total_flow, which counts every push since the last clear and
// saturates at 2^32-1. A new request may be taken while a result still waits
// at the output.
module max_flow_augmenting_path
    import mfap_pkg::*;
#(
    parameter int MAX_NODES      = MaxNodesDef,
    parameter int RESIDUAL_WIDTH = ResidualWidthDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IdxW-1:0]   cfg_index,
    input  logic [NodeW-1:0]  cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        action,
    input  logic [NodeW-1:0]  end_a,
    input  logic [NodeW-1:0]  end_b,
    input  logic [CapW-1:0]   capacity,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [FlowW-1:0]  total_flow
);

    cfg_t             cfg_reg, cfg_next;
    core_stat_t       stat;
    logic             out_valid_reg, out_valid_next;
    logic [FlowW-1:0] total_flow_reg, total_flow_next;
    logic             out_room;
    logic             req_take;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_NODE_COUNT: cfg_next.node_count  = cfg_data;
                REG_SOURCE:     cfg_next.source_node = cfg_data;
                REG_SINK:       cfg_next.sink_node   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Output register
    always_comb
    begin
        out_room        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg && out_stall;
        total_flow_next = total_flow_reg;
        if (stat.emit)
        begin
            out_valid_next  = 1'b1;
            total_flow_next = stat.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count  <= NodeW'(127);
            cfg_reg.source_node <= NodeW'(1);
            cfg_reg.sink_node   <= NodeW'(2);
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_flow_reg <= total_flow_next;
    end

    assign req_take = in_valid && !stat.busy;

    mfap_core #(
        .MAX_NODES      (MAX_NODES),
        .RESIDUAL_WIDTH (RESIDUAL_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .req_take     (req_take),
        .req_action   (action),
        .req_end_a    (end_a),
        .req_end_b    (end_b),
        .req_capacity (capacity),
        .out_room     (out_room),
        .stat         (stat)
    );

    assign in_stall   = stat.busy;
    assign out_valid  = out_valid_reg;
    assign total_flow = total_flow_reg;

endmodule

// File: rtl/core/mfap_checker.sv
module mfap_checker
    import mfap_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic [1:0]       action,
    input logic             out_valid,
    input logic             out_stall,
    input logic [FlowW-1:0] total_flow
);

    // A waiting result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(total_flow))
        else $error("stalled result changed");

    // Clear starts a sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_CLEAR |=> in_stall)
        else $error("clear request did not start sweep");

    // Solve keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && action == ACT_SOLVE |=> in_stall)
        else $error("solve request did not hold input");

    // Results appear only out of a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without request in progress");

endmodule

bind max_flow_augmenting_path mfap_checker u_mfap_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .total_flow (total_flow)
);

// File: tb/sv/tb_max_flow_augmenting_path.sv
`timescale 1ns / 1ps

module tb_max_flow_augmenting_path;
    import mfap_pkg::*;

    localparam int Nodes = MaxNodesDef;

    typedef struct {
        action_t          act;
        logic [NodeW-1:0] a;
        logic [NodeW-1:0] b;
        logic [CapW-1:0]  cap;
    } flow_req_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [IdxW-1:0]   cfg_index;
    logic [NodeW-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        action;
    logic [NodeW-1:0]  end_a;
    logic [NodeW-1:0]  end_b;
    logic [CapW-1:0]   capacity;
    logic              out_valid;
    logic              out_stall;
    logic [FlowW-1:0]  total_flow;

    max_flow_augmenting_path dut (.*);

    // Shadow state of the block
    logic [31:0]      res_cap [Nodes][Nodes];
    bit               seen [Nodes];
    int unsigned      came_from [Nodes];
    int unsigned      dfs_stack [Nodes];
    logic [FlowW-1:0] flow_acc;
    int unsigned      cfg_nodes;
    int unsigned      cfg_src;
    int unsigned      cfg_snk;

    flow_req_t        pending_reqs [$];
    logic [FlowW-1:0] flow_expected [$];
    int               send_idle_pct;
    int               stall_pct;
    int               errors;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] sat_sum(logic [31:0] x, logic [31:0] y);
        logic [32:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Depth-first search over positive residual entries, highest node pushed first
    function automatic bit find_route(int unsigned n, int unsigned s, int unsigned t);
        int unsigned sp;
        int unsigned u;
        sp = 0;
        foreach (seen[i]) seen[i] = 1'b0;
        seen[s] = 1'b1;
        dfs_stack[sp++] = s;
        while (sp > 0)
        begin
            u = dfs_stack[--sp];
            if (u == t)
                return 1'b1;
            for (int v = n; v >= 1; v--)
            begin
                if (!seen[v] && res_cap[u][v] > 0 && sp < Nodes)
                begin
                    seen[v] = 1'b1;
                    came_from[v] = u;
                    dfs_stack[sp++] = v;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void run_max_flow();
        int unsigned n;
        int unsigned v;
        int unsigned u;
        int unsigned guard;
        logic [31:0] bn;
        n = (cfg_nodes < Nodes) ? cfg_nodes : Nodes - 1;
        if (cfg_src < 1 || cfg_src > n || cfg_snk < 1 || cfg_snk > n || cfg_src == cfg_snk)
            return;
        while (find_route(n, cfg_src, cfg_snk))
        begin
            bn = 32'hFFFF_FFFF;
            v = cfg_snk;
            for (guard = 0; v != cfg_src && guard < Nodes; guard++)
            begin
                u = came_from[v] % Nodes;
                if (res_cap[u][v] < bn)
                    bn = res_cap[u][v];
                v = u;
            end
            v = cfg_snk;
            for (guard = 0; v != cfg_src && guard < Nodes; guard++)
            begin
                u = came_from[v] % Nodes;
                res_cap[u][v] = res_cap[u][v] - bn;
                res_cap[v][u] = sat_sum(res_cap[v][u], bn);
                v = u;
            end
            if (bn >= FlowMax - flow_acc)
                flow_acc = FlowMax;
            else
                flow_acc = flow_acc + bn;
        end
    endfunction

    function automatic void clear_graph();
        foreach (res_cap[i, j]) res_cap[i][j] = '0;
        flow_acc = '0;
    endfunction

    // Apply one accepted request to the shadow state
    function automatic void apply_request(flow_req_t r);
        case (r.act)
            ACT_CLEAR: clear_graph();
            ACT_ADD:
                if (r.a != 0 && r.b != 0 && r.a != r.b)
                begin
                    res_cap[r.a][r.b] = sat_sum(res_cap[r.a][r.b], r.cap);
                    res_cap[r.b][r.a] = sat_sum(res_cap[r.b][r.a], r.cap);
                end
            ACT_SOLVE:
            begin
                run_max_flow();
                flow_expected.insert(flow_expected.size(), flow_acc);
            end
            default: ;
        endcase
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        flow_req_t r;
        flow_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action   <= ACT_NONE;
            end_a    <= '0;
            end_b    <= '0;
            capacity <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                r.act = action_t'(action);
                r.a   = end_a;
                r.b   = end_b;
                r.cap = capacity;
                apply_request(r);
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_reqs.pop_front();
                    action   <= nxt.act;
                    end_a    <= nxt.a;
                    end_b    <= nxt.b;
                    capacity <= nxt.cap;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (flow_expected.size() == 0)
                begin
                    $error("total_flow: no result expected, got %0d", total_flow);
                    errors++;
                end
                else if (total_flow !== flow_expected[0])
                begin
                    $error("total_flow: expected %0d, got %0d", flow_expected[0], total_flow);
                    errors++;
                    void'(flow_expected.pop_front());
                end
                else
                    void'(flow_expected.pop_front());
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic push_req(action_t act, int a, int b, int cap);
        flow_req_t r;
        r.act = act;
        r.a   = NodeW'(a);
        r.b   = NodeW'(b);
        r.cap = CapW'(cap);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // Wait until every request is taken, every result is in, and the block is idle
    task automatic drain();
        while (pending_reqs.size() > 0 || in_valid || flow_expected.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= NodeW'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_NODE_COUNT: cfg_nodes = value;
            REG_SOURCE:     cfg_src = value;
            REG_SINK:       cfg_snk = value;
            default: ;
        endcase
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
        endcase
    endtask

    // Random graph traffic, mostly over nodes 1..span, starting from an empty graph
    task automatic random_traffic(int count, int span);
        int pick;
        push_req(ACT_CLEAR, 0, 0, 0);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
                push_req(ACT_ADD, $urandom_range(span, 1), $urandom_range(span, 1),
                         ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(50));
            else if (pick < 66)
                push_req(ACT_ADD, $urandom_range(127), $urandom_range(127), $urandom);
            else if (pick < 94)
                push_req(ACT_SOLVE, $urandom_range(127), $urandom_range(127), $urandom);
            else if (pick < 97)
                push_req(ACT_NONE, $urandom_range(127), $urandom_range(127), $urandom);
            else if (pick < 98)
                push_req(ACT_CLEAR, $urandom_range(127), $urandom_range(127), $urandom);
            else
                push_req(ACT_SOLVE, 0, 0, 0);
        end
    endtask

    initial
    begin
        int nc;
        int src;
        int snk;
        errors        = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cfg_we        = 1'b0;
        cfg_index     = REG_NODE_COUNT;
        cfg_data      = '0;
        cfg_nodes     = 127;
        cfg_src       = 1;
        cfg_snk       = 2;
        clear_graph();
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: defaults, bad edges, extremes, parallel edges, repeated solve
        push_req(ACT_SOLVE, 0, 0, 0);
        push_req(ACT_ADD, 0, 5, 100);
        push_req(ACT_ADD, 5, 0, 100);
        push_req(ACT_ADD, 7, 7, 100);
        push_req(ACT_ADD, 1, 2, 65535);
        push_req(ACT_ADD, 2, 1, 65535);
        push_req(ACT_ADD, 1, 2, 0);
        push_req(ACT_NONE, 1, 2, 500);
        push_req(ACT_SOLVE, 127, 127, 65535);
        push_req(ACT_SOLVE, 0, 0, 0);
        push_req(ACT_ADD, 1, 127, 40);
        push_req(ACT_ADD, 127, 2, 30);
        push_req(ACT_ADD, 127, 64, 9);
        push_req(ACT_ADD, 64, 2, 12);
        push_req(ACT_SOLVE, 0, 0, 0);
        push_req(ACT_CLEAR, 127, 127, 65535);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();

        // Bad terminals and unused register index
        write_reg(REG_UNUSED, 5);
        write_reg(REG_NODE_COUNT, 4);
        write_reg(REG_SOURCE, 0);
        write_reg(REG_SINK, 4);
        push_req(ACT_ADD, 1, 4, 10);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_SOURCE, 1);
        write_reg(REG_SINK, 5);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_SINK, 1);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_NODE_COUNT, 0);
        write_reg(REG_SINK, 4);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();
        write_reg(REG_NODE_COUNT, 1);
        push_req(ACT_SOLVE, 0, 0, 0);
        drain();

        // Random phases, mostly small graphs
        for (int p = 0; p < 12; p++)
        begin
            set_idling(p);
            if (p == 5)
            begin
                nc = 127; src = 127; snk = 1;
            end
            else if (p == 9)
            begin
                nc = 2; src = 2; snk = 1;
            end
            else
            begin
                nc  = $urandom_range(9, 3);
                src = $urandom_range(nc, 1);
                snk = (src % nc) + 1;
            end
            write_reg(REG_NODE_COUNT, nc);
            write_reg(REG_SOURCE, src);
            write_reg(REG_SINK, snk);
            if (p == 5)
            begin
                // Sparse graph spread over the whole node range
                push_req(ACT_CLEAR, 0, 0, 0);
                for (int i = 0; i < 40; i++)
                    if ($urandom_range(3) == 0)
                        push_req(ACT_SOLVE, 0, 0, 0);
                    else
                        push_req(ACT_ADD, $urandom_range(127, 1), $urandom_range(127, 1),
                                 $urandom_range(65535));
                push_req(ACT_ADD, 127, 64, 77);
                push_req(ACT_ADD, 64, 1, 50);
                push_req(ACT_SOLVE, 0, 0, 0);
            end
            else
                random_traffic(40, nc + $urandom_range(1));
            drain();
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
